@@ design/plf_pkg.sv @@
// Shared types, constants and letter/cell helper functions for the Playfair core.
package plf_pkg;

  // Square geometry and letter codes
  localparam int SQ_SIDE  = 5;
  localparam int SQ_CELLS = 25;
  localparam int LETTERS  = 26;
  localparam int LETTER_W = 5;
  localparam int CELL_W   = 5;
  localparam int ROW_W    = 3;

  localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
  localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;
  localparam logic [CELL_W-1:0]   CELL_MAX = 5'd25;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [CELL_W-1:0]   cell_t;
  typedef logic [ROW_W-1:0]    coord_t;

  // Command codes carried in tuser
  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_KEY   = 2'd1,
    CMD_END   = 2'd2,
    CMD_PAIR  = 2'd3
  } cmd_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_KEY,
    ST_FILL,
    ST_PLACE_RD,
    ST_KEY_RD,
    ST_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic clear_marks;
    logic place_key;
    logic place_fill;
    logic load_out;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic fill_done;
    logic out_free;
  } stat_t;

  // Saturate codes above Z, fold J to I
  function automatic letter_t norm_letter(input logic [LETTER_W-1:0] v);
    letter_t l;
    l = (v > LETTER_Z) ? LETTER_Z : v;
    if (l == LETTER_J) l = LETTER_I;
    return l;
  endfunction

  // Letter held by a cell of the alphabetic square
  function automatic letter_t square_reset(input cell_t c);
    return (c < LETTER_J) ? c : c + 5'd1;
  endfunction

  // Cell of a letter in the alphabetic square; J shares the cell of I
  function automatic cell_t place_reset(input letter_t l);
    cell_t c;
    if (l < LETTER_J)       c = l;
    else if (l == LETTER_J) c = LETTER_I;
    else                    c = l - 5'd1;
    return c;
  endfunction

  function automatic coord_t cell_row(input cell_t c);
    coord_t r;
    if (c >= 5'd20)      r = 3'd4;
    else if (c >= 5'd15) r = 3'd3;
    else if (c >= 5'd10) r = 3'd2;
    else if (c >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic coord_t cell_col(input cell_t c);
    cell_t  base;
    coord_t r;
    r    = cell_row(c);
    base = {r, 2'b00} + {2'b00, r};
    return coord_t'(c - base);
  endfunction

  function automatic cell_t cell_at(input coord_t r, input coord_t c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  // One step along a row or column with wrap: forward to encrypt, back to decrypt
  function automatic coord_t wrap_step(input coord_t v, input logic dec);
    coord_t n;
    if (dec) n = (v == 3'd0) ? 3'(SQ_SIDE - 1) : v - 3'd1;
    else     n = (v == 3'(SQ_SIDE - 1)) ? 3'd0 : v + 3'd1;
    return n;
  endfunction

endpackage

@@ design/plf_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
module plf_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

@@ design/plf_ctrl.sv @@
// Controller state machine sequencing key build, fill and pair lookup.
module plf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [1:0]     s_tuser,
  input  plf_pkg::stat_t stat,
  output plf_pkg::ctl_t  ctl
);

  plf_pkg::state_t state;
  plf_pkg::state_t state_next;
  plf_pkg::cmd_t   in_cmd;

  assign in_cmd = plf_pkg::cmd_t'(s_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      plf_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          case (in_cmd)
            plf_pkg::CMD_BEGIN: state_next = plf_pkg::ST_BEGIN;
            plf_pkg::CMD_KEY:   state_next = plf_pkg::ST_KEY;
            plf_pkg::CMD_END:   state_next = plf_pkg::ST_FILL;
            plf_pkg::CMD_PAIR:  state_next = plf_pkg::ST_PLACE_RD;
            default:            state_next = plf_pkg::ST_IDLE;
          endcase
        end
      end
      plf_pkg::ST_BEGIN:    state_next = plf_pkg::ST_IDLE;
      plf_pkg::ST_KEY:      state_next = plf_pkg::ST_IDLE;
      plf_pkg::ST_FILL:     if (stat.fill_done) state_next = plf_pkg::ST_IDLE;
      plf_pkg::ST_PLACE_RD: state_next = plf_pkg::ST_KEY_RD;
      plf_pkg::ST_KEY_RD:   state_next = plf_pkg::ST_OUT;
      plf_pkg::ST_OUT:      if (stat.out_free) state_next = plf_pkg::ST_IDLE;
      default:              state_next = plf_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready        = 1'b0;
    ctl             = '0;
    case (state)
      plf_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        ctl.capture = s_tvalid;
      end
      plf_pkg::ST_BEGIN: ctl.clear_marks = 1'b1;
      plf_pkg::ST_KEY:   ctl.place_key   = 1'b1;
      plf_pkg::ST_FILL:  ctl.place_fill  = 1'b1;
      plf_pkg::ST_OUT:   ctl.load_out    = stat.out_free;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ design/plf_datapath.sv @@
// Datapath: key square and letter place stores, marks, fill counter, pair lookup.
module plf_datapath (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    s_tdata,
  input  plf_pkg::ctl_t  ctl,
  output plf_pkg::stat_t stat,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [15:0]    m_tdata
);

  plf_pkg::letter_t key_a, key_b;
  logic             dec;
  plf_pkg::letter_t fill_letter;
  plf_pkg::cell_t   fill_count;
  logic [plf_pkg::LETTERS-1:0]  used;
  logic [plf_pkg::SQ_CELLS-1:0] sq_vld;
  logic [plf_pkg::LETTERS-1:0]  pl_vld;
  plf_pkg::letter_t out_first, out_second;

  plf_pkg::letter_t place_l;
  logic             place_en;

  // Place one letter at the next free cell
  assign place_l  = ctl.place_key ? key_a : fill_letter;
  assign place_en = (ctl.place_key || (ctl.place_fill && fill_letter != plf_pkg::LETTER_J))
                    && !used[place_l] && (fill_count < plf_pkg::CELL_MAX);

  assign stat.fill_done = (fill_letter == plf_pkg::LETTER_Z);
  assign stat.out_free  = !m_tvalid || m_tready;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= '0;
      fill_count  <= '0;
      fill_letter <= '0;
      sq_vld      <= '0;
      pl_vld      <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (ctl.clear_marks) begin
        used       <= '0;
        fill_count <= '0;
      end
      if (place_en) begin
        used[place_l]      <= 1'b1;
        fill_count         <= fill_count + 5'd1;
        sq_vld[fill_count] <= 1'b1;
        pl_vld[place_l]    <= 1'b1;
      end
      if (ctl.capture) begin
        fill_letter <= '0;
      end else if (ctl.place_fill) begin
        fill_letter <= fill_letter + 5'd1;
      end
      if (ctl.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Transaction capture
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      key_a <= plf_pkg::norm_letter(s_tdata[4:0]);
      key_b <= plf_pkg::norm_letter(s_tdata[9:5]);
      dec   <= s_tdata[10];
    end
  end

  // Letter place store
  plf_pkg::cell_t pl_q_a, pl_q_b, pl_rst_a, pl_rst_b;
  logic           pl_sel_a, pl_sel_b;
  plf_pkg::cell_t p1, p2;

  plf_ram #(.WIDTH(plf_pkg::CELL_W), .DEPTH(plf_pkg::LETTERS)) u_place_ram (
    .clk       (clk),
    .wr_en     (place_en),
    .wr_addr   (place_l),
    .wr_data   (fill_count),
    .rd_addr_a (key_a),
    .rd_data_a (pl_q_a),
    .rd_addr_b (key_b),
    .rd_data_b (pl_q_b)
  );

  always_ff @(posedge clk) begin
    pl_sel_a <= pl_vld[key_a];
    pl_sel_b <= pl_vld[key_b];
    pl_rst_a <= plf_pkg::place_reset(key_a);
    pl_rst_b <= plf_pkg::place_reset(key_b);
  end

  assign p1 = pl_sel_a ? pl_q_a : pl_rst_a;
  assign p2 = pl_sel_b ? pl_q_b : pl_rst_b;

  // Playfair rule: same row, same column, or rectangle swap
  plf_pkg::coord_t r1, c1, r2, c2;
  plf_pkg::cell_t  sq_addr_a, sq_addr_b;

  always_comb begin
    r1 = plf_pkg::cell_row(p1);
    c1 = plf_pkg::cell_col(p1);
    r2 = plf_pkg::cell_row(p2);
    c2 = plf_pkg::cell_col(p2);
    if (r1 == r2) begin
      sq_addr_a = plf_pkg::cell_at(r1, plf_pkg::wrap_step(c1, dec));
      sq_addr_b = plf_pkg::cell_at(r2, plf_pkg::wrap_step(c2, dec));
    end else if (c1 == c2) begin
      sq_addr_a = plf_pkg::cell_at(plf_pkg::wrap_step(r1, dec), c1);
      sq_addr_b = plf_pkg::cell_at(plf_pkg::wrap_step(r2, dec), c2);
    end else begin
      sq_addr_a = plf_pkg::cell_at(r1, c2);
      sq_addr_b = plf_pkg::cell_at(r2, c1);
    end
  end

  // Key square store
  plf_pkg::letter_t sq_q_a, sq_q_b, sq_rst_a, sq_rst_b;
  logic             sq_sel_a, sq_sel_b;
  plf_pkg::letter_t o1, o2;

  plf_ram #(.WIDTH(plf_pkg::LETTER_W), .DEPTH(plf_pkg::SQ_CELLS)) u_square_ram (
    .clk       (clk),
    .wr_en     (place_en),
    .wr_addr   (fill_count),
    .wr_data   (place_l),
    .rd_addr_a (sq_addr_a),
    .rd_data_a (sq_q_a),
    .rd_addr_b (sq_addr_b),
    .rd_data_b (sq_q_b)
  );

  always_ff @(posedge clk) begin
    sq_sel_a <= sq_vld[sq_addr_a];
    sq_sel_b <= sq_vld[sq_addr_b];
    sq_rst_a <= plf_pkg::square_reset(sq_addr_a);
    sq_rst_b <= plf_pkg::square_reset(sq_addr_b);
  end

  assign o1 = sq_sel_a ? sq_q_a : sq_rst_a;
  assign o2 = sq_sel_b ? sq_q_b : sq_rst_b;

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_first  <= o1;
      out_second <= o2;
    end
  end

  assign m_tdata = {6'b0, out_second, out_first};

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= plf_pkg::CELL_MAX)
    else $error("fill count beyond square size");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    place_en |=> fill_count == $past(fill_count) + 5'd1)
    else $error("placement did not advance fill count");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while held");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_marks |=> (used == '0 && fill_count == '0))
    else $error("begin key left marks set");

endmodule

@@ design/playfair_digraph_cipher_core.sv @@
// Top level of the Playfair digraph cipher core: controller plus datapath.
//
// Usage: items arrive on the slave stream (s_tvalid/s_tready). s_tuser carries
// the command: begin key, key letter, end key, or cipher pair. s_tdata carries
// the letters and the decrypt flag. Only cipher pairs produce a transaction on
// the master stream (m_tvalid/m_tready), carrying the transformed letters.
// Timing: one item is handled at a time by the controller. Begin key and key
// letter each pass through their own state and return to idle; end key holds
// in the fill state while the fill walks all 26 letters, one a cycle. A cipher
// pair passes two registered reads in series (letter places, then key square
// cells) and then the output register, which raises m_tvalid.
// Reset: the square reads as the plain alphabet without J, marks and fill count
// clear; valid bits on both stores stand in for the reset contents.
// Stall: the result waits in the output register; the next item is accepted
// meanwhile, and a further pair waits in its last step until the register frees.
module playfair_digraph_cipher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // letter_first[4:0], letter_second[9:5], decrypt[10]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // out_first[4:0], out_second[9:5]
);

  plf_pkg::ctl_t  ctl;
  plf_pkg::stat_t stat;

  plf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .ctl      (ctl)
  );

  plf_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .ctl      (ctl),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ tb/playfair_digraph_cipher_checker.sv @@
// Checker for the Playfair core: predicts each cipher pair and compares it with the output stream.
module playfair_digraph_cipher_checker
  import plf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // letter_first[4:0], letter_second[9:5], decrypt[10]
  input  logic [1:0]  s_tuser,   // command[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // out_first[4:0], out_second[9:5]
  output int          errors,
  output int          pairs_due,
  output int          pairs_checked
);

  // second letter in the upper half so that the struct matches tdata[9:0]
  typedef struct packed {
    letter_t second;
    letter_t first;
  } pair_t;

  // Predicted key square and its bookkeeping
  letter_t square_cell [SQ_CELLS];
  cell_t   letter_cell [LETTERS];
  bit      letter_placed [LETTERS];
  int      cells_filled;

  // Transformed pairs still to come out of the block
  pair_t   cipher_pairs_due [$];

  // Codes past Z read as Z; J shares the place of I
  function automatic letter_t fold_letter(input logic [4:0] code);
    letter_t l;
    l = code;
    if (code > LETTER_Z) l = LETTER_Z;
    else if (code == LETTER_J) l = LETTER_I;
    return l;
  endfunction

  // Plain alphabet without J, row by row
  task automatic reset_square();
    int slot;
    slot = 0;
    for (int l = 0; l < LETTERS; l++) begin
      if (l != LETTER_J) begin
        square_cell[slot] = letter_t'(l);
        letter_cell[l]    = cell_t'(slot);
        slot++;
      end
      letter_placed[l] = 1'b0;
    end
    letter_cell[LETTER_J] = letter_cell[LETTER_I];
    cells_filled = 0;
  endtask

  // Put a letter in the next free cell unless it is already there or the square is full
  function automatic void place_letter(input letter_t l);
    if (letter_placed[l] || cells_filled >= SQ_CELLS) return;
    square_cell[cells_filled] = l;
    letter_cell[l]            = cell_t'(cells_filled);
    letter_placed[l]          = 1'b1;
    cells_filled++;
  endfunction

  // Row, column or rectangle rule on the current square
  function automatic pair_t encipher_pair(input letter_t a, input letter_t b, input logic dec);
    int unsigned p1, p2, r1, c1, r2, c2, stp;
    pair_t res;
    stp = dec ? SQ_SIDE - 1 : 1;
    p1  = letter_cell[a] % SQ_CELLS;
    p2  = letter_cell[b] % SQ_CELLS;
    r1  = p1 / SQ_SIDE;
    c1  = p1 % SQ_SIDE;
    r2  = p2 / SQ_SIDE;
    c2  = p2 % SQ_SIDE;
    if (r1 == r2) begin
      res.first  = square_cell[r1 * SQ_SIDE + (c1 + stp) % SQ_SIDE];
      res.second = square_cell[r2 * SQ_SIDE + (c2 + stp) % SQ_SIDE];
    end else if (c1 == c2) begin
      res.first  = square_cell[((r1 + stp) % SQ_SIDE) * SQ_SIDE + c1];
      res.second = square_cell[((r2 + stp) % SQ_SIDE) * SQ_SIDE + c2];
    end else begin
      res.first  = square_cell[r1 * SQ_SIDE + c2];
      res.second = square_cell[r2 * SQ_SIDE + c1];
    end
    return res;
  endfunction

  // Watch both streams at each rising edge
  always @(posedge clk) begin : watch
    pair_t got;
    pair_t due;
    cmd_t  cmd;
    if (rst) begin
      reset_square();
      cipher_pairs_due.delete();
      errors        <= 0;
      pairs_checked <= 0;
    end else begin
      // output transaction against the oldest prediction
      if (m_tvalid && m_tready) begin
        got = pair_t'(m_tdata[9:0]);
        if (cipher_pairs_due.size() == 0) begin
          $error("unexpected result: out_first %0d, out_second %0d", got.first, got.second);
          errors <= errors + 1;
        end else begin
          due = cipher_pairs_due.pop_front();
          if (got.first !== due.first) begin
            $error("out_first: expected %0d, got %0d", due.first, got.first);
            errors <= errors + 1;
          end else if (got.second !== due.second) begin
            $error("out_second: expected %0d, got %0d", due.second, got.second);
            errors <= errors + 1;
          end
          if (got.first !== due.first && got.second !== due.second)
            $error("out_second: expected %0d, got %0d", due.second, got.second);
          pairs_checked <= pairs_checked + 1;
        end
      end
      // input transaction updates the square or queues a prediction
      if (s_tvalid && s_tready) begin
        cmd = cmd_t'(s_tuser);
        case (cmd)
          CMD_BEGIN: begin
            foreach (letter_placed[l]) letter_placed[l] = 1'b0;
            cells_filled = 0;
          end
          CMD_KEY: place_letter(fold_letter(s_tdata[4:0]));
          CMD_END: begin
            for (int l = 0; l < LETTERS; l++)
              if (l != LETTER_J) place_letter(letter_t'(l));
          end
          default: begin
            cipher_pairs_due.push_back(encipher_pair(fold_letter(s_tdata[4:0]),
                                                     fold_letter(s_tdata[9:5]), s_tdata[10]));
          end
        endcase
      end
    end
    pairs_due <= cipher_pairs_due.size();
  end

endmodule

@@ tb/playfair_digraph_cipher_core_tb.sv @@
// Testbench top for the Playfair core: stimulus, output back-pressure and final verdict.
module playfair_digraph_cipher_core_tb;
  import plf_pkg::*;

  localparam int SINK_HOLD_CYCLES = 250;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  int fail_count;
  int pairs_due;
  int pairs_checked;

  int src_idle_pct;
  int sink_idle_pct;
  bit hold_req;
  int items_sent;
  int pairs_sent;
  int keys_ended;

  playfair_digraph_cipher_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  playfair_digraph_cipher_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .errors        (fail_count),
    .pairs_due     (pairs_due),
    .pairs_checked (pairs_checked)
  );

  // Clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Overall time limit
  initial begin
    #4000000;
    $display("** playfair_digraph_cipher_core: FAILED **");
    $finish;
  end

  // Receiver: random back-pressure, or one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Mostly proper letters, now and then a code past Z
  function automatic letter_t rand_letter();
    if ($urandom_range(99) < 85) return letter_t'($urandom_range(25));
    return letter_t'($urandom_range(31));
  endfunction

  // One input transaction, with random idle cycles in front
  task automatic push_item(input cmd_t cmd, input letter_t first, input letter_t second,
                           input logic dec);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {5'b0, dec, second, first};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (cmd == CMD_PAIR) pairs_sent++;
    if (cmd == CMD_END) keys_ended++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted pair has come out
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pairs_due != 0);
  endtask

  // A key build followed by a run of pairs, or a short burst of noise
  task automatic run_session();
    int n;
    if ($urandom_range(99) < 82) begin
      push_item(CMD_BEGIN, rand_letter(), rand_letter(), 1'($urandom_range(1)));
      n = $urandom_range(12);
      repeat (n) begin
        // occasional pair against a half-built square
        if ($urandom_range(99) < 4)
          push_item(CMD_PAIR, rand_letter(), rand_letter(), 1'($urandom_range(1)));
        push_item(CMD_KEY, rand_letter(), rand_letter(), 1'($urandom_range(1)));
      end
      push_item(CMD_END, rand_letter(), rand_letter(), 1'($urandom_range(1)));
      n = $urandom_range(40, 5);
      repeat (n) push_item(CMD_PAIR, rand_letter(), rand_letter(), 1'($urandom_range(1)));
    end else begin
      n = $urandom_range(6, 1);
      repeat (n)
        push_item(cmd_t'($urandom_range(3)), rand_letter(), rand_letter(),
                  1'($urandom_range(1)));
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = CMD_BEGIN;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_req      = 1'b0;
    items_sent    = 0;
    pairs_sent    = 0;
    keys_ended    = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // plain square from reset: row, column, saturation and J folding
    push_item(CMD_PAIR, 0, 1, 0);
    push_item(CMD_PAIR, 0, 21, 1);
    push_item(CMD_PAIR, 31, 9, 0);
    // key letter with no begin, then a pair on the half-rewritten square
    push_item(CMD_KEY, 4, 31, 1);
    push_item(CMD_PAIR, 0, 4, 1);
    // key with J, saturated codes and repeats, then a fill
    push_item(CMD_BEGIN, 31, 31, 1);
    push_item(CMD_KEY, 9, 0, 0);
    push_item(CMD_KEY, 31, 17, 1);
    push_item(CMD_KEY, 26, 3, 0);
    push_item(CMD_KEY, 8, 25, 1);
    push_item(CMD_KEY, 0, 12, 0);
    push_item(CMD_END, 5, 30, 1);
    // square full: this key letter is dropped
    push_item(CMD_KEY, 5, 0, 0);
    // identical letters, extremes, both directions
    push_item(CMD_PAIR, 0, 0, 0);
    push_item(CMD_PAIR, 9, 8, 1);
    push_item(CMD_PAIR, 25, 0, 0);
    push_item(CMD_PAIR, 0, 25, 1);
    push_item(CMD_PAIR, 31, 30, 1);
    push_item(CMD_PAIR, 3, 17, 0);
    push_item(CMD_PAIR, 3, 17, 1);
    push_item(CMD_PAIR, 12, 4, 0);
    push_item(CMD_PAIR, 22, 15, 1);

    // sender idles less than the receiver
    src_idle_pct  = 38;
    sink_idle_pct = 50;
    while (items_sent < 470) run_session();
    wait_drain();

    // receiver idles less than the sender
    src_idle_pct  = 50;
    sink_idle_pct = 38;
    while (items_sent < 920) run_session();

    // full rate both sides
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    while (items_sent < 1100) run_session();

    // long output stall while pairs keep coming, then a full drain
    hold_req = 1'b1;
    repeat (30) push_item(CMD_PAIR, rand_letter(), rand_letter(), 1'($urandom_range(1)));
    wait_drain();

    while (items_sent < 1370) run_session();

    wait_drain();
    repeat (40) @(negedge clk);

    $display("Run covered %0d input transactions: %0d cipher pairs and %0d key fills.",
             items_sent, pairs_sent, keys_ended);
    $display("%0d result transactions checked across three idling mixes and one long stall.",
             pairs_checked);
    if (fail_count == 0 && pairs_due == 0) begin
      $display("** playfair_digraph_cipher_core: PASSED **");
    end else begin
      $display("** playfair_digraph_cipher_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/plf_pkg.sv
design/plf_ram.sv
design/plf_ctrl.sv
design/plf_datapath.sv
design/playfair_digraph_cipher_core.sv
tb/playfair_digraph_cipher_checker.sv
tb/playfair_digraph_cipher_core_tb.sv
